FILE: src/ogn_pkg.sv
// Shared types, constants and the gradient function of the octave noise block.
// Used by every module of the block; depends on nothing.
package ogn_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TBL_AW    = 8;
   localparam int MAX_OCT   = 8;
   localparam int DIV_BITS  = 37;
   localparam int DSR_BITS  = 20;

   localparam logic [16:0] ONE_Q = 17'h10000;

   // csr indexes
   localparam logic [1:0] CSR_OCTAVES = 2'd0;
   localparam logic [1:0] CSR_PERSIST = 2'd1;
   localparam logic [1:0] CSR_LACUN   = 2'd2;

   // item modes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [7:0]  table_index;
      logic [7:0]  table_value;
      logic [23:0] x_coord;
      logic [23:0] y_coord;
   } ogn_item_type;

   typedef struct packed {
      logic [3:0]  octave_count;
      logic [15:0] persistence;
      logic [14:0] lacunarity;
   } ogn_cfg_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [DSR_BITS-1:0] divisor;
   } ogn_div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
   } ogn_div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SX0, ST_SX1, ST_SY0, ST_SY1,
      ST_FU0, ST_FU1, ST_FU2, ST_FV0, ST_FV1, ST_FV2,
      ST_L0, ST_L1, ST_L2, ST_L3,
      ST_AC0, ST_AC1, ST_AC2, ST_AC3,
      ST_DIVS, ST_DIVW
   } ogn_state_type;

   // four-way gradient, second axis weighs two
   function automatic logic signed [21:0] grad(input logic [7:0] h,
                                               input logic signed [17:0] dx,
                                               input logic signed [17:0] dy);
      logic signed [21:0] u;
      logic signed [21:0] v;
      logic signed [21:0] su;
      logic signed [21:0] sv;
      u  = h[1] ? 22'(dy) : 22'(dx);
      v  = h[1] ? 22'(dx) : 22'(dy);
      su = h[0] ? -u : u;
      sv = h[1] ? -(v <<< 1) : (v <<< 1);
      return su + sv;
   endfunction

endpackage

FILE: src/ogn_front.sv
// Front end: takes request words and holds them in a two-entry queue.
// Depends on ogn_pkg.
module ogn_front import ogn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ogn_item_type in_item,
   output logic         q_valid,
   output ogn_item_type q_item,
   input  logic         q_pop
);

   ogn_item_type ent_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = ent_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !(q_pop && q_valid)) count_in = count_ff + 2'd1;
      else if (!push && q_pop && q_valid) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (q_pop && q_valid) rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= in_item;
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != 2'd0) else $error("pop from empty queue");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !q_pop) |=> count_ff == 2'd2)
      else $error("full queue changed without pop");
`endif

endmodule

FILE: src/ogn_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ogn_pkg.
module ogn_div import ogn_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ogn_div_req_type req,
   output ogn_div_rsp_type rsp
);

   logic                busy_ff, done_ff;
   logic [5:0]          cnt_ff;
   logic [DSR_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [DSR_BITS-1:0] dsr_ff;
   logic [DSR_BITS:0]   shifted;

   assign shifted = {rem_ff, quo_ff[DIV_BITS-1]};

   // one trial subtract
   always_comb begin
      if (shifted >= {1'b0, dsr_ff}) begin
         rem_in = DSR_BITS'(shifted - {1'b0, dsr_ff});
         quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
      end else begin
         rem_in = shifted[DSR_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(DIV_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         quo_ff <= req.dividend;
         dsr_ff <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: src/ogn_back.sv
// Back end: permutation memory and the octave sequencer on one shared multiplier.
// Depends on ogn_pkg and ogn_div.
module ogn_back import ogn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ogn_cfg_type  cfg,
   input  logic         q_valid,
   input  ogn_item_type q_item,
   output logic         q_pop,
   output logic         rsp_valid,
   output logic [15:0]  rsp_noise_value,
   output logic         rsp_clipped
);

   ogn_state_type state_ff, state_in;

   // permutation memory
   logic [7:0]        mem [1 << TBL_AW];
   logic [TBL_AW-1:0] rd_addr;
   logic [7:0]        rdata_ff;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;

   ogn_div_req_type div_req;
   ogn_div_rsp_type div_rsp;

   logic [23:0]        x_ff, y_ff, sx_ff, sy_ff;
   logic [39:0]        freq_ff;
   logic [16:0]        amp_ff, u_ff, v_ff;
   logic [19:0]        ampsum_ff;
   logic signed [21:0] total_ff, ga_ff, r0_ff;
   logic [3:0]         oct_ff, noct_ff;
   logic [46:0]        lo_ff;
   logic [20:0]        q_ff;
   logic [7:0]         pa_ff, pb_ff, aa_ff, ab_ff, ba_ff;
   logic               rsp_valid_ff, rsp_clip_ff;
   logic [15:0]        rsp_val_ff;

   logic [3:0]         noct;
   logic [15:0]        t_cur, t2, t3;
   logic [21:0]        q_in;
   logic [7:0]         cx, cy;
   logic signed [17:0] x0, y0, x1, y1;
   logic signed [21:0] g_aa, g_ba, g_ab, g_bb, lerp_v, r1, nv;
   logic               last_oct;

   // octave count clamp
   always_comb begin
      if (cfg.octave_count == 4'd0) noct = 4'd1;
      else if (cfg.octave_count > 4'(MAX_OCT)) noct = 4'(MAX_OCT);
      else noct = cfg.octave_count;
   end

   assign cx = sx_ff[FRAC_BITS +: TBL_AW];
   assign cy = sy_ff[FRAC_BITS +: TBL_AW];
   assign x0 = {2'b00, sx_ff[FRAC_BITS-1:0]};
   assign y0 = {2'b00, sy_ff[FRAC_BITS-1:0]};
   assign x1 = x0 - 18'sd65536;
   assign y1 = y0 - 18'sd65536;
   assign g_aa = grad(aa_ff, x0, y0);
   assign g_ba = grad(ba_ff, x1, y0);
   assign g_ab = grad(ab_ff, x0, y1);
   assign g_bb = grad(rdata_ff, x1, y1);
   assign lerp_v = $signed(prod_ff[37:16]);
   assign r1 = ga_ff + lerp_v;
   assign nv = r0_ff + lerp_v;
   assign last_oct = (oct_ff == noct_ff - 4'd1);

   // fade helpers
   assign t_cur = (state_ff == ST_FU1 || state_ff == ST_FU2) ?
                  sx_ff[15:0] : sy_ff[15:0];
   assign t2 = prod_ff[31:16];
   assign t3 = prod_ff[31:16];
   assign q_in = 22'(t2) * 22'd6 + 22'd655360 - 22'(t_cur) * 22'd15;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (q_valid && q_item.mode == MODE_EVAL) state_in = ST_SX0;
         ST_SX0:  state_in = ST_SX1;
         ST_SX1:  state_in = ST_SY0;
         ST_SY0:  state_in = ST_SY1;
         ST_SY1:  state_in = ST_FU0;
         ST_FU0:  state_in = ST_FU1;
         ST_FU1:  state_in = ST_FU2;
         ST_FU2:  state_in = ST_FV0;
         ST_FV0:  state_in = ST_FV1;
         ST_FV1:  state_in = ST_FV2;
         ST_FV2:  state_in = ST_L0;
         ST_L0:   state_in = ST_L1;
         ST_L1:   state_in = ST_L2;
         ST_L2:   state_in = ST_L3;
         ST_L3:   state_in = ST_AC0;
         ST_AC0:  state_in = ST_AC1;
         ST_AC1:  state_in = ST_AC2;
         ST_AC2:  state_in = ST_AC3;
         ST_AC3:  state_in = last_oct ? ST_DIVS : ST_SX0;
         ST_DIVS: state_in = total_ff[21] ? ST_IDLE : ST_DIVW;
         ST_DIVW: if (div_rsp.done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs: pop, memory address, multiplier operands, divider start
   always_comb begin
      q_pop         = 1'b0;
      rd_addr       = cx;
      mul_a         = '0;
      mul_b         = '0;
      div_req.start    = 1'b0;
      div_req.dividend = {total_ff[20:0], 16'b0};
      div_req.divisor  = ampsum_ff;
      unique case (state_ff)
         ST_IDLE: q_pop = q_valid;
         ST_SX0: begin
            mul_a = 33'(x_ff); mul_b = {1'b0, freq_ff[31:0]};
         end
         ST_SX1: begin
            mul_a = 33'(x_ff); mul_b = 33'(freq_ff[39:32]);
         end
         ST_SY0: begin
            mul_a = 33'(y_ff); mul_b = {1'b0, freq_ff[31:0]};
         end
         ST_SY1: begin
            mul_a = 33'(y_ff); mul_b = 33'(freq_ff[39:32]);
         end
         ST_FU0: begin
            rd_addr = cx;
            mul_a = 33'(sx_ff[15:0]); mul_b = 33'(sx_ff[15:0]);
         end
         ST_FU1: begin
            rd_addr = cx + 8'd1;
            mul_a = 33'(t2); mul_b = 33'(sx_ff[15:0]);
         end
         ST_FU2: begin
            rd_addr = pa_ff + cy;
            mul_a = 33'(t3); mul_b = 33'(q_ff);
         end
         ST_FV0: begin
            rd_addr = pa_ff + cy + 8'd1;
            mul_a = 33'(sy_ff[15:0]); mul_b = 33'(sy_ff[15:0]);
         end
         ST_FV1: begin
            rd_addr = pb_ff + cy;
            mul_a = 33'(t2); mul_b = 33'(sy_ff[15:0]);
         end
         ST_FV2: begin
            rd_addr = pb_ff + cy + 8'd1;
            mul_a = 33'(t3); mul_b = 33'(q_ff);
         end
         ST_L0: begin
            // keep the last corner on the read port for the second lerp
            rd_addr = pb_ff + cy + 8'd1;
            mul_a = 33'(g_ba - g_aa); mul_b = 33'(u_ff);
         end
         ST_L1: begin
            mul_a = 33'(g_bb - g_ab); mul_b = 33'(u_ff);
         end
         ST_L2: begin
            mul_a = 33'(r1 - r0_ff); mul_b = 33'(v_ff);
         end
         ST_L3: begin
            mul_a = 33'(nv + 22'sd65536); mul_b = 33'(amp_ff);
         end
         ST_AC0: begin
            mul_a = 33'(amp_ff); mul_b = 33'(cfg.persistence);
         end
         ST_AC1: begin
            mul_a = {1'b0, freq_ff[31:0]}; mul_b = 33'(cfg.lacunarity);
         end
         ST_AC2: begin
            mul_a = 33'(freq_ff[39:32]); mul_b = 33'(cfg.lacunarity);
         end
         ST_AC3: ;
         ST_DIVS: div_req.start = !total_ff[21];
         ST_DIVW: ;
         default: ;
      endcase
   end

   ogn_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && q_item.mode == MODE_LOAD)
         mem[q_item.table_index] <= q_item.table_value;
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         oct_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_DIVS && total_ff[21]) ||
                         (state_ff == ST_DIVW && div_rsp.done);
         if (state_ff == ST_IDLE) oct_ff <= '0;
         else if (state_ff == ST_AC3) oct_ff <= oct_ff + 4'd1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            x_ff      <= q_item.x_coord;
            y_ff      <= q_item.y_coord;
            freq_ff   <= 40'(ONE_Q);
            amp_ff    <= ONE_Q;
            ampsum_ff <= '0;
            total_ff  <= '0;
            noct_ff   <= noct;
         end
         ST_SX1: lo_ff <= 47'(prod_ff[39:0]);
         ST_SY0: sx_ff <= lo_ff[39:16] + {prod_ff[7:0], 16'b0};
         ST_SY1: lo_ff <= 47'(prod_ff[39:0]);
         ST_FU0: sy_ff <= lo_ff[39:16] + {prod_ff[7:0], 16'b0};
         ST_FU1: begin
            q_ff  <= q_in[20:0];
            pa_ff <= rdata_ff;
         end
         ST_FU2: pb_ff <= rdata_ff;
         ST_FV0: begin
            u_ff  <= prod_ff[32:16];
            aa_ff <= rdata_ff;
         end
         ST_FV1: begin
            q_ff  <= q_in[20:0];
            ab_ff <= rdata_ff;
         end
         ST_FV2: ba_ff <= rdata_ff;
         ST_L0: begin
            v_ff  <= prod_ff[32:16];
            ga_ff <= g_aa;
         end
         ST_L1: begin
            r0_ff <= g_aa + lerp_v;
            ga_ff <= g_ab;
         end
         ST_AC0: begin
            total_ff  <= total_ff + $signed(prod_ff[38:17]);
            ampsum_ff <= ampsum_ff + 20'(amp_ff);
         end
         ST_AC1: amp_ff <= prod_ff[32:16];
         ST_AC2: lo_ff <= prod_ff[46:0];
         ST_AC3: freq_ff <= 40'((52'(lo_ff) + {prod_ff[19:0], 32'b0}) >> 12);
         ST_DIVS: begin
            rsp_val_ff  <= '0;
            rsp_clip_ff <= 1'b1;
         end
         ST_DIVW: begin
            rsp_clip_ff <= div_rsp.quotient > 37'(ONE_Q);
            rsp_val_ff  <= (div_rsp.quotient > 37'h0FFFF) ? 16'hFFFF :
                           div_rsp.quotient[15:0];
         end
         default: ;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_val_ff;
   assign rsp_clipped     = rsp_clip_ff;

`ifndef NO_ASSERTIONS
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_DIVS || $past(state_ff) == ST_DIVW))
      else $error("result without finished evaluation");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_IDLE || state_ff == ST_SX0))
      else $error("pop outside idle");
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> state_ff == ST_DIVW)
      else $error("divider started outside division step");
   a_oct_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_AC3 |-> oct_ff < noct_ff)
      else $error("octave counter overran");
`endif

endmodule

FILE: src/octave_gradient_noise_2d.sv
// Top level of the 2D octave gradient noise block: csr registers and wiring.
// Depends on ogn_pkg, ogn_front, ogn_back (which holds ogn_div).
//
// A request word with mode 0 writes one byte of the 256-entry permutation
// table; all entries must be written before any evaluation. A word with
// mode 1 returns one result: each octave runs in sequence on the shared
// multiplier and memory port (two coordinate products per axis, two
// three-product fades, three lerps, accumulate, amplitude and frequency
// updates), followed by a 37-step division unless the sum is negative.
// Loads retire one per cycle while no evaluation is in progress. Words
// wait in a two-entry queue; busy is high while it is full. Each result is
// shown for exactly one cycle on rsp_valid and cannot be held off.
module octave_gradient_noise_2d import ogn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_table_index,
   input  logic [7:0]  req_table_value,
   input  logic [23:0] req_x_coord,
   input  logic [23:0] req_y_coord,
   output logic        rsp_valid,
   output logic [15:0] rsp_noise_value,
   output logic        rsp_clipped,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   ogn_cfg_type  cfg_ff;
   ogn_item_type in_item, q_item;
   logic         q_valid, q_pop;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.octave_count <= 4'd4;
         cfg_ff.persistence  <= 16'd32768;
         cfg_ff.lacunarity   <= 15'd8192;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OCTAVES: cfg_ff.octave_count <= csr_wdata[3:0];
            CSR_PERSIST: cfg_ff.persistence  <= csr_wdata;
            CSR_LACUN:   cfg_ff.lacunarity   <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   assign in_item.mode        = req_mode;
   assign in_item.table_index = req_table_index;
   assign in_item.table_value = req_table_value;
   assign in_item.x_coord     = req_x_coord;
   assign in_item.y_coord     = req_y_coord;

   ogn_front u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .in_item (in_item),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   ogn_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value),
      .rsp_clipped     (rsp_clipped)
   );

endmodule

FILE: verif/octave_gradient_noise_2d_tb.sv
// Self-checking testbench for octave_gradient_noise_2d: loads the permutation table,
// sweeps csr settings and checks each noise word against a built-in predictor.
// Depends on ogn_pkg and the RTL under src.
module octave_gradient_noise_2d_tb;
   import ogn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint UNIT   = 64'd65536;
   localparam int     LAT    = 260;
   localparam int     N_RAND = 32;

   typedef struct {
      logic [15:0] noise;
      logic        clipped;
   } noise_word_type;

   // predicts noise words and compares them in order
   class noise_scoreboard;
      logic [7:0]        perm [256];
      logic [3:0]        octaves;
      logic [15:0]       persist;
      logic [14:0]       lacun;
      noise_word_type    pending_q [$];
      int                errors;
      int                n_eval;
      int                n_load;
      int                n_seen;
      int                n_clip;

      function new();
         octaves = 4'd4;
         persist = 16'd32768;
         lacun   = 15'd8192;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_OCTAVES: octaves = data[3:0];
            CSR_PERSIST: persist = data;
            CSR_LACUN:   lacun   = data[14:0];
            default: ;
         endcase
      endfunction

      // floor(a*b / 2^sh), operands small enough for 64 bits
      function longint floor_mul(longint a, longint b, int sh);
         return (a * b) >>> sh;
      endfunction

      function longint fade(longint t);
         longint t2, t3;
         t2 = (t * t) >>> 16;
         t3 = (t2 * t) >>> 16;
         return (t3 * (6 * t2 + 10 * UNIT - 15 * t)) >>> 16;
      endfunction

      function longint slope(logic [7:0] h, longint dx, longint dy);
         longint u, v;
         u = h[1] ? dy : dx;
         v = h[1] ? dx : dy;
         return (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v);
      endfunction

      function longint blend(longint a, longint b, longint t);
         return a + floor_mul(b - a, t, 16);
      endfunction

      // one octave at the scaled Q8.16 position
      function longint cell_noise(logic [23:0] sx, logic [23:0] sy);
         logic [7:0] cx, cy, cx1, cy1, pa, pb;
         longint     xf, yf, u, v, r0, r1;
         cx  = sx[23:16];
         cy  = sy[23:16];
         cx1 = cx + 8'd1;
         cy1 = cy + 8'd1;
         xf  = longint'(sx[15:0]);
         yf  = longint'(sy[15:0]);
         u   = fade(xf);
         v   = fade(yf);
         pa  = perm[cx];
         pb  = perm[cx1];
         r0  = blend(slope(perm[8'(pa + cy)], xf, yf),
                     slope(perm[8'(pb + cy)], xf - UNIT, yf), u);
         r1  = blend(slope(perm[8'(pa + cy1)], xf, yf - UNIT),
                     slope(perm[8'(pb + cy1)], xf - UNIT, yf - UNIT), u);
         return blend(r0, r1, v);
      endfunction

      // notes an accepted request word
      function void note(logic mode, logic [7:0] idx, logic [7:0] val,
                         logic [23:0] x, logic [23:0] y);
         int             n;
         logic [127:0]   p;
         logic [39:0]    freq;
         longint         amp, ampsum, total, nv, r;
         noise_word_type w;
         if (mode == MODE_LOAD) begin
            perm[idx] = val;
            n_load++;
            return;
         end
         n_eval++;
         n = (octaves == 0) ? 1 : (octaves > MAX_OCT) ? MAX_OCT : int'(octaves);
         freq   = 40'(UNIT);
         amp    = UNIT;
         ampsum = 0;
         total  = 0;
         for (int i = 0; i < n; i++) begin
            logic [23:0] sx, sy;
            p  = (128'(x) * 128'(freq)) >> 16;
            sx = p[23:0];
            p  = (128'(y) * 128'(freq)) >> 16;
            sy = p[23:0];
            nv = cell_noise(sx, sy);
            total  += floor_mul(nv + UNIT, amp, 17);
            ampsum += amp;
            amp     = (amp * longint'(persist)) >>> 16;
            p       = (128'(freq) * 128'(lacun)) >> 12;
            freq    = p[39:0];
         end
         if (total < 0) begin
            w.noise   = 16'd0;
            w.clipped = 1'b1;
         end else begin
            r = (total <<< 16) / ampsum;
            w.clipped = (r > UNIT);
            w.noise   = (r > UNIT - 1) ? 16'hFFFF : r[15:0];
         end
         pending_q.push_back(w);
      endfunction

      function void report(string what);
         $display("%0t mismatch: %s", $time, what);
         errors++;
      endfunction

      // compares one result word with the oldest expectation
      function void check(logic [15:0] noise, logic clipped);
         noise_word_type w;
         n_seen++;
         if (clipped) n_clip++;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected word noise=%h clipped=%b", noise, clipped));
            return;
         end
         w = pending_q.pop_front();
         if (noise !== w.noise)
            report($sformatf("noise_value %h, want %h", noise, w.noise));
         if (clipped !== w.clipped)
            report($sformatf("clipped %b, want %b", clipped, w.clipped));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_mode = 1'b0;
   logic [7:0]  req_table_index = '0;
   logic [7:0]  req_table_value = '0;
   logic [23:0] req_x_coord = '0;
   logic [23:0] req_y_coord = '0;
   logic        rsp_valid;
   logic [15:0] rsp_noise_value;
   logic        rsp_clipped;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   noise_scoreboard sb;
   int              gap_max;

   octave_gradient_noise_2d dut (.*);

   always #2 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && sb != null)
         sb.check(rsp_noise_value, rsp_clipped);
   end

   // sends one word; start stays high when the next word follows at once
   task automatic send(logic mode, logic [7:0] idx, logic [7:0] val,
                       logic [23:0] x, logic [23:0] y);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= mode;
      req_table_index <= idx;
      req_table_value <= val;
      req_x_coord     <= x;
      req_y_coord     <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note(mode, idx, val, x, y);
   endtask

   task automatic send_eval(logic [23:0] x, logic [23:0] y);
      send(MODE_EVAL, 8'($urandom), 8'($urandom), x, y);
   endtask

   // waits for every expected word, then for the block to settle
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_q.size() > 0) @(posedge clock);
      repeat (LAT) @(posedge clock);
   endtask

   // writes all three registers in consecutive cycles
   task automatic write_cfg(logic [3:0] oct, logic [15:0] pers, logic [14:0] lac);
      csr_we    <= 1'b1;
      csr_index <= CSR_OCTAVES;
      csr_wdata <= 16'(oct);
      @(posedge clock);
      sb.set_reg(CSR_OCTAVES, 16'(oct));
      csr_index <= CSR_PERSIST;
      csr_wdata <= pers;
      @(posedge clock);
      sb.set_reg(CSR_PERSIST, pers);
      csr_index <= CSR_LACUN;
      csr_wdata <= 16'(lac);
      @(posedge clock);
      sb.set_reg(CSR_LACUN, 16'(lac));
      csr_we <= 1'b0;
   endtask

   // mostly evaluations with random coordinates, some table rewrites
   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 30 == 0) gap_max = (i % 60 == 0) ? 0 : 5;
         if ($urandom_range(0, 99) < 15)
            send(MODE_LOAD, 8'($urandom), 8'($urandom), 24'($urandom), 24'($urandom));
         else if ($urandom_range(0, 3) == 0)
            send_eval(24'($urandom_range(0, 24'h03FFFF)), 24'($urandom_range(0, 24'h03FFFF)));
         else
            send_eval(24'($urandom), 24'($urandom));
         if (i == count / 2) begin
            // hold off until the pipeline is empty
            start <= 1'b0;
            while (sb.pending_q.size() > 0) @(posedge clock);
         end
      end
   endtask

   initial begin
      logic [7:0] shuffle [256];
      sb      = new();
      gap_max = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole table with a shuffled permutation
      for (int i = 0; i < 256; i++) shuffle[i] = 8'(i);
      for (int i = 255; i > 0; i--) begin
         int j;
         logic [7:0] t;
         j = $urandom_range(0, i);
         t = shuffle[i];
         shuffle[i] = shuffle[j];
         shuffle[j] = t;
      end
      for (int i = 0; i < 256; i++) send(MODE_LOAD, 8'(i), shuffle[i], '0, '0);

      // directed points at reset settings: origin, wrap cells, extreme fractions
      send_eval(24'h000000, 24'h000000);
      send_eval(24'hFFFFFF, 24'hFFFFFF);
      send_eval(24'h00FFFF, 24'h000000);
      send_eval(24'h000000, 24'h00FFFF);
      send_eval(24'hFF8000, 24'h7F8000);
      send_eval(24'h010000, 24'hFF0000);
      send_eval(24'h808080, 24'h7F7F7F);
      send_eval(24'hAAAAAA, 24'h555555);
      send(MODE_LOAD, 8'hFF, shuffle[255], 24'hFFFFFF, 24'hFFFFFF);
      send(MODE_LOAD, 8'h00, shuffle[0], 24'h000000, 24'h000000);
      gap_max = 5;
      random_phase(N_RAND);
      drain();

      // single octave, zero persistence, lowest lacunarity
      write_cfg(4'd1, 16'd0, 15'd4096);
      send_eval(24'hFFFFFF, 24'h000000);
      send_eval(24'h000000, 24'hFFFFFF);
      random_phase(N_RAND);
      drain();

      // most octaves, highest persistence and lacunarity (frequency wraps)
      write_cfg(4'd8, 16'hFFFF, 15'h7FFF);
      send_eval(24'hFFFFFF, 24'hFFFFFF);
      send_eval(24'h00FFFF, 24'h00FFFF);
      random_phase(N_RAND);
      drain();

      // out-of-range octave counts, random factors
      write_cfg(4'd0, 16'($urandom), 15'($urandom_range(4096, 32767)));
      send_eval(24'h123456, 24'hFEDCBA);
      random_phase(N_RAND / 2);
      drain();
      write_cfg(4'd15, 16'($urandom), 15'($urandom_range(4096, 32767)));
      random_phase(N_RAND / 2);
      drain();

      if (sb.pending_q.size() > 0)
         sb.report($sformatf("%0d words never arrived", sb.pending_q.size()));
      $display("covered %0d evaluations and %0d table loads over five csr settings",
               sb.n_eval, sb.n_load);
      $display("%0d noise words checked, %0d of them clipped", sb.n_seen, sb.n_clip);
      if (sb.errors == 0) begin
         $display("octave_gradient_noise_2d_tb: done, clean");
      end else begin
         $display("octave_gradient_noise_2d_tb: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("octave_gradient_noise_2d_tb: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
src/ogn_pkg.sv
src/ogn_front.sv
src/ogn_div.sv
src/ogn_back.sv
src/octave_gradient_noise_2d.sv
verif/octave_gradient_noise_2d_tb.sv
